/* sv/motor_safety_monitor_macros.svh */
// assertion macros for the motor safety monitor
// expects clk and rst in the scope of the module that uses them
`ifndef MOTOR_SAFETY_MONITOR_MACROS_SVH
`define MOTOR_SAFETY_MONITOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define MSM_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define MSM_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

/* sv/msm_pkg.sv */
// shared constants, register codes, types and the crc byte fold
// used by the monitor top level and its crc unit; no dependencies
`default_nettype none

package msm_pkg;

  localparam int WINDOW_SAMPLES_DEF = 8;
  localparam int NUM_FLAGS          = 6;
  localparam int ADDR_W             = 5;
  localparam int DATA_W             = 32;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_TOP  = 16'h8000;
  localparam logic [15:0] U16_MAX  = 16'hFFFF;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_OVERSPEED_SET   = 3'd0;
  localparam logic [2:0] REG_OVERSPEED_CLR   = 3'd1;
  localparam logic [2:0] REG_OVERCURRENT_SET = 3'd2;
  localparam logic [2:0] REG_OVERCURRENT_CLR = 3'd3;
  localparam logic [2:0] REG_VOLTAGE_LOW     = 3'd4;
  localparam logic [2:0] REG_VOLTAGE_HIGH    = 3'd5;
  localparam logic [2:0] REG_VOLTAGE_MARGIN  = 3'd6;
  localparam logic [2:0] REG_VIBRATION_LIMIT = 3'd7;

  localparam logic [15:0] RST_OVERSPEED_SET   = 16'd1500;
  localparam logic [15:0] RST_OVERSPEED_CLR   = 16'd1400;
  localparam logic [15:0] RST_OVERCURRENT_SET = 16'd5000;
  localparam logic [15:0] RST_OVERCURRENT_CLR = 16'd4500;
  localparam logic [15:0] RST_VOLTAGE_LOW     = 16'd10000;
  localparam logic [15:0] RST_VOLTAGE_HIGH    = 16'd14000;
  localparam logic [15:0] RST_VOLTAGE_MARGIN  = 16'd500;
  localparam logic [15:0] RST_VIBRATION_LIMIT = 16'd800;

  typedef struct packed {
    logic init;
    logic step;
  } crc_ctl_t;

  // one byte of crc-16/ccitt, msb first
  function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/msm_if.sv */
// item channels of the monitor: sensor snapshot in, fault report out
// valid/ready handshake; no dependencies
`default_nettype none

interface msm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] speed_rpm;
  logic [15:0] filtered_current_ma;
  logic [15:0] raw_current_ma;
  logic [15:0] supply_mv;
  logic        lid_is_open;
  logic        adc_fault;

  modport source (output valid, speed_rpm, filtered_current_ma, raw_current_ma,
                  supply_mv, lid_is_open, adc_fault, input ready);
  modport sink (input valid, speed_rpm, filtered_current_ma, raw_current_ma,
                supply_mv, lid_is_open, adc_fault, output ready);
endinterface

interface msm_out_if;
  logic        valid;
  logic        ready;
  logic        overspeed_flag;
  logic        overcurrent_flag;
  logic        lid_flag;
  logic        voltage_flag;
  logic        vibration_flag;
  logic        diag_flag;
  logic [15:0] flags_crc;

  modport source (output valid, overspeed_flag, overcurrent_flag, lid_flag,
                  voltage_flag, vibration_flag, diag_flag, flags_crc, input ready);
  modport sink (input valid, overspeed_flag, overcurrent_flag, lid_flag,
                voltage_flag, vibration_flag, diag_flag, flags_crc, output ready);
endinterface

`default_nettype wire

/* sv/msm_cell.sv */
// one cell of the sample window: holds a sample, folds running min/max
// no package dependency; chained by the monitor top level
`default_nettype none

module msm_cell (
  input  logic        clk,
  input  logic        shift_en,
  input  logic [15:0] sample_in,
  input  logic [15:0] min_in,
  input  logic [15:0] max_in,
  output logic [15:0] sample_out,
  output logic [15:0] min_out,
  output logic [15:0] max_out
);

  logic [15:0] sample;
  logic [15:0] min_q;
  logic [15:0] max_q;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample <= sample_in;
    end
    // running extremes move one cell per cycle
    min_q <= (sample < min_in) ? sample : min_in;
    max_q <= (sample > max_in) ? sample : max_in;
  end

  assign sample_out = sample;
  assign min_out    = min_q;
  assign max_out    = max_q;

endmodule

`default_nettype wire

/* sv/msm_crc.sv */
// crc-16/ccitt unit folding one flag byte per cycle while step is set
// depends on msm_pkg for the fold function and control struct
`default_nettype none

module msm_crc import msm_pkg::*; (
  input  logic        clk,
  input  crc_ctl_t    ctl,
  input  logic        flag,
  output logic [15:0] crc
);

  logic [15:0] crc_reg;

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      crc_reg <= CRC_INIT;
    end else if (ctl.step) begin
      crc_reg <= crc_fold_byte(crc_reg, {7'b0000000, flag});
    end
  end

  assign crc = crc_reg;

endmodule

`default_nettype wire

/* sv/motor_safety_monitor.sv */
// motor safety monitor top level: apb registers, fault logic, sequencer
// depends on msm_pkg, msm_if, msm_cell, msm_crc and the assertion macros
`default_nettype none
`include "motor_safety_monitor_macros.svh"

// Takes one sensor snapshot per item and returns one fault report with six
// flags and a crc-16/ccitt (init ffff, no reflection) over the six flag bytes.
// Overspeed and overcurrent use set/clear hysteresis, the voltage fault sets
// outside [low, high] and clears only inside [low + margin, high - margin],
// computed without wrap. Raw current shifts into a chain of WINDOW_SAMPLES
// cells; once the window is full the vibration flag follows its peak-to-peak
// against the limit, and it holds while the window fills. Each item passes
// through the sequencer states in order: scan, while the running min/max
// ripples one cell per cycle through the chain; crc, while the crc unit
// folds one flag byte per cycle; done, which loads the report register once
// it is free; then back to idle, where the next snapshot can be taken. One
// item is in work at a time; the report register lets the next snapshot in
// while a report waits, and a second finished report holds the sequencer
// until the first is taken. No clearing pass is needed after reset, the fill
// count guards the window. Registers sit at byte address 4 * index and must
// be written by the user only while idle; the block does not enforce this.

module motor_safety_monitor import msm_pkg::*; #(
  parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  msm_in_if.sink             snapshot,
  msm_out_if.source          report,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int CNT_W = $clog2(WINDOW_SAMPLES + 1);
  localparam logic [CNT_W-1:0] WIN_FULL  = CNT_W'(WINDOW_SAMPLES);
  localparam logic [2:0]       LAST_FLAG = 3'(NUM_FLAGS - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CRC  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // configuration registers
  logic [15:0] overspeed_set;
  logic [15:0] overspeed_clr;
  logic [15:0] overcurrent_set;
  logic [15:0] overcurrent_clr;
  logic [15:0] voltage_low;
  logic [15:0] voltage_high;
  logic [15:0] voltage_margin;
  logic [15:0] vibration_limit;

  logic [2:0]  reg_idx;
  logic        reg_write;

  // control and fault state
  logic [1:0]       state;
  logic [CNT_W-1:0] scan_cnt;
  logic [CNT_W-1:0] fill;
  logic [2:0]       crc_cnt;
  logic             overspeed_held;
  logic             overcurrent_held;
  logic             voltage_held;
  logic             vibration_held;
  logic             lid_q;
  logic             diag_q;

  logic             accept;
  logic             load_report;
  logic [16:0]      clear_lo;
  logic [16:0]      clear_hi;
  logic             volt_outside;
  logic             volt_clear_band;
  logic [NUM_FLAGS-1:0] flags;
  logic [15:0]      crc;
  crc_ctl_t         crc_ctl;

  // cell chain links, the last sample link leaves the chain unread
  logic [15:0] link_sample [0:WINDOW_SAMPLES];
  logic [15:0] link_min    [0:WINDOW_SAMPLES];
  logic [15:0] link_max    [0:WINDOW_SAMPLES];

  // ---------------------------------------------------------------- apb port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      overspeed_set   <= RST_OVERSPEED_SET;
      overspeed_clr   <= RST_OVERSPEED_CLR;
      overcurrent_set <= RST_OVERCURRENT_SET;
      overcurrent_clr <= RST_OVERCURRENT_CLR;
      voltage_low     <= RST_VOLTAGE_LOW;
      voltage_high    <= RST_VOLTAGE_HIGH;
      voltage_margin  <= RST_VOLTAGE_MARGIN;
      vibration_limit <= RST_VIBRATION_LIMIT;
    end else if (reg_write) begin
      unique case (reg_idx)
        REG_OVERSPEED_SET:   overspeed_set   <= pwdata[15:0];
        REG_OVERSPEED_CLR:   overspeed_clr   <= pwdata[15:0];
        REG_OVERCURRENT_SET: overcurrent_set <= pwdata[15:0];
        REG_OVERCURRENT_CLR: overcurrent_clr <= pwdata[15:0];
        REG_VOLTAGE_LOW:     voltage_low     <= pwdata[15:0];
        REG_VOLTAGE_HIGH:    voltage_high    <= pwdata[15:0];
        REG_VOLTAGE_MARGIN:  voltage_margin  <= pwdata[15:0];
        REG_VIBRATION_LIMIT: vibration_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OVERSPEED_SET:   prdata = {16'h0000, overspeed_set};
      REG_OVERSPEED_CLR:   prdata = {16'h0000, overspeed_clr};
      REG_OVERCURRENT_SET: prdata = {16'h0000, overcurrent_set};
      REG_OVERCURRENT_CLR: prdata = {16'h0000, overcurrent_clr};
      REG_VOLTAGE_LOW:     prdata = {16'h0000, voltage_low};
      REG_VOLTAGE_HIGH:    prdata = {16'h0000, voltage_high};
      REG_VOLTAGE_MARGIN:  prdata = {16'h0000, voltage_margin};
      REG_VIBRATION_LIMIT: prdata = {16'h0000, vibration_limit};
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- fault compares
  assign snapshot.ready = (state == ST_IDLE);
  assign accept         = snapshot.valid && snapshot.ready;

  // clear band edges carry one extra bit so they never wrap
  assign clear_lo = {1'b0, voltage_low} + {1'b0, voltage_margin};
  assign clear_hi = {1'b0, voltage_high} - {1'b0, voltage_margin};

  assign volt_outside    = (snapshot.supply_mv < voltage_low) ||
                           (snapshot.supply_mv > voltage_high);
  // negative upper edge means an empty band
  assign volt_clear_band = ({1'b0, snapshot.supply_mv} >= clear_lo) &&
                           !clear_hi[16] &&
                           (snapshot.supply_mv <= clear_hi[15:0]);

  // ------------------------------------------------------------- cell chain
  assign link_min[0] = U16_MAX;
  assign link_max[0] = 16'h0000;

  for (genvar g = 0; g < WINDOW_SAMPLES; g++) begin : g_cell
    msm_cell u_cell (
      .clk        (clk),
      .shift_en   (accept),
      .sample_in  (link_sample[g]),
      .min_in     (link_min[g]),
      .max_in     (link_max[g]),
      .sample_out (link_sample[g+1]),
      .min_out    (link_min[g+1]),
      .max_out    (link_max[g+1])
    );
  end

  assign link_sample[0] = snapshot.raw_current_ma;

  // ---------------------------------------------------------------- crc unit
  assign flags = {diag_q, vibration_held, voltage_held, lid_q,
                  overcurrent_held, overspeed_held};

  assign crc_ctl.init = accept;
  assign crc_ctl.step = (state == ST_CRC);

  msm_crc u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .flag (flags[crc_cnt]),
    .crc  (crc)
  );

  // --------------------------------------------------------------- sequencer
  assign load_report = (state == ST_DONE) && (!report.valid || report.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      scan_cnt         <= '0;
      crc_cnt          <= '0;
      fill             <= '0;
      overspeed_held   <= 1'b0;
      overcurrent_held <= 1'b0;
      voltage_held     <= 1'b0;
      vibration_held   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state    <= ST_SCAN;
            scan_cnt <= '0;
            if (fill != WIN_FULL) begin
              fill <= fill + 1'b1;
            end
            // hysteresis: set at threshold, clear at or below the lower one
            if (!overspeed_held) begin
              overspeed_held <= (snapshot.speed_rpm >= overspeed_set);
            end else begin
              overspeed_held <= !(snapshot.speed_rpm <= overspeed_clr);
            end
            if (!overcurrent_held) begin
              overcurrent_held <= (snapshot.filtered_current_ma >= overcurrent_set);
            end else begin
              overcurrent_held <= !(snapshot.filtered_current_ma <= overcurrent_clr);
            end
            if (!voltage_held) begin
              voltage_held <= volt_outside;
            end else begin
              voltage_held <= !volt_clear_band;
            end
          end
        end
        ST_SCAN: begin
          // last cell holds the whole window's extremes after the ripple
          if (scan_cnt == WIN_FULL) begin
            state   <= ST_CRC;
            crc_cnt <= '0;
            if (fill == WIN_FULL) begin
              vibration_held <= ((link_max[WINDOW_SAMPLES] - link_min[WINDOW_SAMPLES])
                                 >= vibration_limit);
            end
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        ST_CRC: begin
          if (crc_cnt == LAST_FLAG) begin
            state <= ST_DONE;
          end else begin
            crc_cnt <= crc_cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (load_report) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // pass-through flags captured with the item
  always_ff @(posedge clk) begin
    if (accept) begin
      lid_q  <= snapshot.lid_is_open;
      diag_q <= snapshot.adc_fault;
    end
  end

  // ---------------------------------------------------------- report register
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (load_report) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_report) begin
      report.overspeed_flag   <= overspeed_held;
      report.overcurrent_flag <= overcurrent_held;
      report.lid_flag         <= lid_q;
      report.voltage_flag     <= voltage_held;
      report.vibration_flag   <= vibration_held;
      report.diag_flag        <= diag_q;
      report.flags_crc        <= crc;
    end
  end

  // -------------------------------------------------------------- assertions
  `MSM_ASSERT_NEXT(a_accept_starts_scan, accept, (state == ST_SCAN) && (scan_cnt == '0))
  `MSM_ASSERT_NEXT(a_scan_ends_in_crc, (state == ST_SCAN) && (scan_cnt == WIN_FULL), (state == ST_CRC) && (crc_cnt == '0))
  `MSM_ASSERT_IMP(a_report_from_done, $rose(report.valid), $past(state) == ST_DONE)

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for motor_safety_monitor: snapshot items in, fault reports out
// depends on msm_pkg, msm_if and the monitor rtl; registers are driven over the apb port
`default_nettype none

module testbench import msm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_SAMPLES   = WINDOW_SAMPLES_DEF;
  // time that one item occupies the monitor at this window
  localparam int DUT_LATENCY      = WINDOW_SAMPLES + 9;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT      = 500_000;

  // one sensor snapshot as the input channel carries it
  typedef struct packed {
    logic [15:0] speed_rpm;
    logic [15:0] filtered_current_ma;
    logic [15:0] raw_current_ma;
    logic [15:0] supply_mv;
    logic        lid_is_open;
    logic        adc_fault;
  } snapshot_t;

  // one fault report as the output channel carries it
  typedef struct packed {
    logic        overspeed_flag;
    logic        overcurrent_flag;
    logic        lid_flag;
    logic        voltage_flag;
    logic        vibration_flag;
    logic        diag_flag;
    logic [15:0] flags_crc;
  } report_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  msm_in_if  snapshot_ch ();
  msm_out_if report_ch ();

  motor_safety_monitor #(
    .WINDOW_SAMPLES(WINDOW_SAMPLES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .snapshot (snapshot_ch),
    .report   (report_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------------------
  // shared state of the bench
  // ---------------------------------------------------------------------------

  // reports still owed by the monitor, oldest first
  report_t     pending_reports[$];
  int          mismatch_count = 0;
  int          report_count   = 0;
  int          cycle_count    = 0;

  // percentage that drives the random idling: per snapshot on the sender, halved on the receiver; 0 means none
  int          idle_pct = 0;
  // a long receiver hold-off is asked for by raising hold_request
  logic        hold_request = 1'b0;
  logic        sink_hold;

  // spread of the raw current in the random part, set per phase
  int          raw_base = 0;
  int unsigned raw_span = 0;

  // predictor copy of the threshold registers, indexed by register code
  logic [15:0] limits [8];

  // predictor copy of the fault and window state
  logic        speed_fault;
  logic        current_fault;
  logic        supply_fault;
  logic        vibration_fault;
  logic [15:0] window_model [WINDOW_SAMPLES];
  int          window_pos;
  int          window_count;

  // ---------------------------------------------------------------------------
  // clock and watchdog
  // ---------------------------------------------------------------------------

  initial begin : clock_gen
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // a stuck handshake or a lost report ends up here
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_predictor();
    limits[REG_OVERSPEED_SET]   = RST_OVERSPEED_SET;
    limits[REG_OVERSPEED_CLR]   = RST_OVERSPEED_CLR;
    limits[REG_OVERCURRENT_SET] = RST_OVERCURRENT_SET;
    limits[REG_OVERCURRENT_CLR] = RST_OVERCURRENT_CLR;
    limits[REG_VOLTAGE_LOW]     = RST_VOLTAGE_LOW;
    limits[REG_VOLTAGE_HIGH]    = RST_VOLTAGE_HIGH;
    limits[REG_VOLTAGE_MARGIN]  = RST_VOLTAGE_MARGIN;
    limits[REG_VIBRATION_LIMIT] = RST_VIBRATION_LIMIT;
    speed_fault     = 1'b0;
    current_fault   = 1'b0;
    supply_fault    = 1'b0;
    vibration_fault = 1'b0;
    foreach (window_model[j]) window_model[j] = 16'h0000;
    window_pos   = 0;
    window_count = 0;
  endfunction

  // set at or above set_at, clear at or below clear_at, each compare as it stands
  function automatic logic next_hysteresis(input logic held, input logic [15:0] value,
                                           input logic [15:0] set_at,
                                           input logic [15:0] clear_at);
    if (!held) return value >= set_at;
    return !(value <= clear_at);
  endfunction

  // crc-16/ccitt, init ffff, msb first, over one byte per flag (0 or 1)
  function automatic logic [15:0] flags_crc16(input logic [NUM_FLAGS-1:0] flags);
    logic [15:0] acc;
    logic [7:0]  octet;
    logic        feedback;
    acc = CRC_INIT;
    for (int i = NUM_FLAGS - 1; i >= 0; i--) begin
      octet = {7'b0, flags[i]};
      for (int b = 7; b >= 0; b--) begin
        feedback = acc[15] ^ octet[b];
        acc = {acc[14:0], 1'b0};
        if (feedback) acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  // advances the predictor state by one snapshot and returns the report it owes
  function automatic report_t predict_report(input snapshot_t s);
    report_t     r;
    int          v;
    int          lo;
    int          hi;
    int          mg;
    logic [15:0] mn;
    logic [15:0] mx;
    speed_fault = next_hysteresis(speed_fault, s.speed_rpm,
                                  limits[REG_OVERSPEED_SET], limits[REG_OVERSPEED_CLR]);
    current_fault = next_hysteresis(current_fault, s.filtered_current_ma,
                                    limits[REG_OVERCURRENT_SET], limits[REG_OVERCURRENT_CLR]);

    // signed 32-bit bounds, so low + margin and high - margin never wrap
    v  = int'(s.supply_mv);
    lo = int'(limits[REG_VOLTAGE_LOW]);
    hi = int'(limits[REG_VOLTAGE_HIGH]);
    mg = int'(limits[REG_VOLTAGE_MARGIN]);
    if (!supply_fault) begin
      if (v < lo || v > hi) supply_fault = 1'b1;
    end else begin
      if (v >= lo + mg && v <= hi - mg) supply_fault = 1'b0;
    end

    window_model[window_pos] = s.raw_current_ma;
    window_pos = (window_pos + 1) % WINDOW_SAMPLES;
    if (window_count < WINDOW_SAMPLES) window_count++;
    // vibration holds while the window fills
    if (window_count >= WINDOW_SAMPLES) begin
      mn = 16'hFFFF;
      mx = 16'h0000;
      foreach (window_model[j]) begin
        if (window_model[j] < mn) mn = window_model[j];
        if (window_model[j] > mx) mx = window_model[j];
      end
      vibration_fault = 16'(mx - mn) >= limits[REG_VIBRATION_LIMIT];
    end

    r.overspeed_flag   = speed_fault;
    r.overcurrent_flag = current_fault;
    r.lid_flag         = s.lid_is_open;
    r.voltage_flag     = supply_fault;
    r.vibration_flag   = vibration_fault;
    r.diag_flag        = s.adc_fault;
    r.flags_crc        = flags_crc16({r.overspeed_flag, r.overcurrent_flag, r.lid_flag,
                                      r.voltage_flag, r.vibration_flag, r.diag_flag});
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic void note_failure(input string msg);
    if (mismatch_count < 10) $display("mismatch: %s", msg);
    mismatch_count++;
  endfunction

  // !== so that an x on an output counts as a mismatch
  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) note_failure($sformatf("%s expected %0h, got %0h", what, want, got));
  endfunction

  function automatic void check_report();
    report_t want;
    if (pending_reports.size() == 0) begin
      note_failure($sformatf("report %0d arrived with no snapshot pending", report_count));
      report_count++;
      return;
    end
    want = pending_reports.pop_front();
    check_field($sformatf("report %0d overspeed_flag", report_count),
                want.overspeed_flag, report_ch.overspeed_flag);
    check_field($sformatf("report %0d overcurrent_flag", report_count),
                want.overcurrent_flag, report_ch.overcurrent_flag);
    check_field($sformatf("report %0d lid_flag", report_count),
                want.lid_flag, report_ch.lid_flag);
    check_field($sformatf("report %0d voltage_flag", report_count),
                want.voltage_flag, report_ch.voltage_flag);
    check_field($sformatf("report %0d vibration_flag", report_count),
                want.vibration_flag, report_ch.vibration_flag);
    check_field($sformatf("report %0d diag_flag", report_count),
                want.diag_flag, report_ch.diag_flag);
    check_field($sformatf("report %0d flags_crc", report_count),
                want.flags_crc, report_ch.flags_crc);
    report_count++;
  endfunction

  // receiver: checks each accepted report, then picks ready for the next cycle.
  // ready and sink_hold are both updated by nonblocking assignments, so what is
  // read here at the edge is the value that the edge itself saw
  initial begin : report_sink
    int stall_left;
    stall_left = 0;
    report_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && report_ch.valid && report_ch.ready) check_report();
      if (sink_hold) begin
        report_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        report_ch.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(199) < idle_pct) begin
        // start a burst with ready low; stall_left counts down the rest of it
        stall_left = $urandom_range(8);
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= 1'b1;
      end
    end
  end

  // long hold-off of the receiver, counted here so that the sender keeps offering
  initial begin : long_hold
    sink_hold = 1'b0;
    forever begin
      wait (hold_request);
      hold_request = 1'b0;
      @(posedge clk);
      sink_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clk);
      sink_hold <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offers one snapshot and waits for its acceptance; valid stays high afterwards
  // so that back-to-back items never see valid lowered and raised in one step
  task automatic send_snapshot(input snapshot_t s);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      snapshot_ch.valid <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk);
    end
    snapshot_ch.valid               <= 1'b1;
    snapshot_ch.speed_rpm           <= s.speed_rpm;
    snapshot_ch.filtered_current_ma <= s.filtered_current_ma;
    snapshot_ch.raw_current_ma      <= s.raw_current_ma;
    snapshot_ch.supply_mv           <= s.supply_mv;
    snapshot_ch.lid_is_open         <= s.lid_is_open;
    snapshot_ch.adc_fault           <= s.adc_fault;
    do @(posedge clk); while (!snapshot_ch.ready);
    pending_reports.push_back(predict_report(s));
  endtask

  task automatic send_fields(input logic [15:0] speed, input logic [15:0] fcur,
                             input logic [15:0] rcur, input logic [15:0] supply,
                             input logic lid, input logic adc);
    snapshot_t s;
    s = '{speed, fcur, rcur, supply, lid, adc};
    send_snapshot(s);
  endtask

  // sender stops offering and waits until every report owed has come back
  task automatic drain_reports();
    snapshot_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // one apb transfer: setup cycle, access cycle, completes when pready is seen
  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [15:0] value,
                            output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    // upper data bits are junk, the register keeps only 16 bits
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // writes one threshold register while the monitor is idle and reads it back
  task automatic write_limit(input logic [2:0] idx, input logic [15:0] value);
    logic [DATA_W-1:0] rdata;
    drain_reports();
    apb_access(1'b1, idx, value, rdata);
    limits[idx] = value;
    apb_access(1'b0, idx, 16'h0000, rdata);
    check_field($sformatf("register %0d readback", idx), {16'h0, limits[idx]},
                {16'h0, rdata[15:0]});
  endtask

  // ---------------------------------------------------------------------------
  // random stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] clamp16(input int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  // mostly close to a threshold so that hysteresis bands get crossed, else anywhere
  function automatic logic [15:0] near_value(input int centre);
    if ($urandom_range(3) == 0) return 16'($urandom);
    return clamp16(centre + int'($urandom_range(80)) - 40);
  endfunction

  function automatic snapshot_t random_snapshot();
    snapshot_t s;
    int        lo;
    int        hi;
    int        mg;
    lo = int'(limits[REG_VOLTAGE_LOW]);
    hi = int'(limits[REG_VOLTAGE_HIGH]);
    mg = int'(limits[REG_VOLTAGE_MARGIN]);
    s.speed_rpm = near_value($urandom_range(1) ? int'(limits[REG_OVERSPEED_SET])
                                               : int'(limits[REG_OVERSPEED_CLR]));
    s.filtered_current_ma = near_value($urandom_range(1) ? int'(limits[REG_OVERCURRENT_SET])
                                                         : int'(limits[REG_OVERCURRENT_CLR]));
    // supply lands around one of the four bounds of the set and clear windows
    case ($urandom_range(3))
      0:       s.supply_mv = near_value(lo);
      1:       s.supply_mv = near_value(hi);
      2:       s.supply_mv = near_value(lo + mg);
      default: s.supply_mv = near_value(hi - mg);
    endcase
    if ($urandom_range(15) == 0) s.raw_current_ma = 16'($urandom);
    else s.raw_current_ma = clamp16(raw_base + int'($urandom_range(raw_span)));
    s.lid_is_open = 1'($urandom_range(1));
    s.adc_fault   = 1'($urandom_range(1));
    return s;
  endfunction

  // a fresh random setting; clear mostly below set, now and then anywhere,
  // and now and then an inverted window or a margin wider than the window
  task automatic program_random_limits();
    logic [15:0] set_at;
    logic [15:0] lo;
    set_at = 16'($urandom);
    write_limit(REG_OVERSPEED_SET, set_at);
    write_limit(REG_OVERSPEED_CLR, ($urandom_range(4) == 0) ? 16'($urandom)
                : clamp16(int'(set_at) - int'($urandom_range(600))));
    set_at = 16'($urandom);
    write_limit(REG_OVERCURRENT_SET, set_at);
    write_limit(REG_OVERCURRENT_CLR, ($urandom_range(4) == 0) ? 16'($urandom)
                : clamp16(int'(set_at) - int'($urandom_range(600))));
    lo = 16'($urandom_range(50000));
    write_limit(REG_VOLTAGE_LOW, lo);
    write_limit(REG_VOLTAGE_HIGH, ($urandom_range(5) == 0) ? 16'($urandom)
                : clamp16(int'(lo) + int'($urandom_range(20000))));
    write_limit(REG_VOLTAGE_MARGIN, ($urandom_range(7) == 0) ? 16'($urandom)
                : 16'($urandom_range(3000)));
    write_limit(REG_VIBRATION_LIMIT, ($urandom_range(7) == 0) ? 16'($urandom)
                : 16'($urandom_range(3000)));
    raw_base = $urandom_range(60000);
    raw_span = $urandom_range(2 * int'(limits[REG_VIBRATION_LIMIT]) + 1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset thresholds: field extremes, every set and clear edge, window fill
  task automatic test_reset_defaults();
    idle_pct = 0;
    // all zero: supply below the window sets the voltage fault
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    // all ones: speed and current set, supply far above keeps voltage set
    send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    // just above clear: both hold; supply well inside clears voltage
    send_fields(16'd1401, 16'd4501, 16'd1000, 16'd12000, 1'b0, 1'b1);
    // exactly at clear: both clear; supply at the upper edge does not set
    send_fields(16'd1400, 16'd4500, 16'd1000, 16'd14000, 1'b1, 1'b0);
    // one below set: no set; supply just above the window sets
    send_fields(16'd1499, 16'd4999, 16'd1000, 16'd14001, 1'b0, 1'b0);
    // exactly at set; supply one above the shrunk upper edge keeps the fault
    send_fields(16'd1500, 16'd5000, 16'd1000, 16'd13501, 1'b1, 1'b1);
    // supply at the shrunk upper edge clears
    send_fields(16'd1500, 16'd5000, 16'd1000, 16'd13500, 1'b0, 1'b0);
    // window now full with 0 and ffff inside: vibration sets
    send_fields(16'd1500, 16'd5000, 16'd1000, 16'd10000, 1'b0, 1'b0);
    // supply just below the window sets, then holds short of the shrunk lower edge
    send_fields(16'd1000, 16'd1000, 16'd1000, 16'd9999, 1'b1, 1'b0);
    send_fields(16'd1000, 16'd1000, 16'd1000, 16'd10499, 1'b0, 1'b1);
    send_fields(16'd1000, 16'd1000, 16'd1000, 16'd10500, 1'b0, 1'b0);
    // extremes have left the window: peak-to-peak one short of the limit, then over
    send_fields(16'h0000, 16'h0000, 16'd1799, 16'd12000, 1'b0, 1'b0);
    send_fields(16'h0000, 16'h0000, 16'd200, 16'd12000, 1'b1, 1'b1);
  endtask

  // clear above set, inverted voltage window, margin wider than the window
  task automatic test_threshold_corners();
    write_limit(REG_OVERSPEED_SET, 16'd100);
    write_limit(REG_OVERSPEED_CLR, 16'd200);
    write_limit(REG_OVERCURRENT_SET, 16'h0000);
    write_limit(REG_OVERCURRENT_CLR, 16'hFFFF);
    write_limit(REG_VOLTAGE_LOW, 16'd2000);
    write_limit(REG_VOLTAGE_HIGH, 16'd1000);
    write_limit(REG_VOLTAGE_MARGIN, 16'h0000);
    // flags toggle on successive items; every supply sets an inverted window
    send_fields(16'd150, 16'h0000, 16'd500, 16'd1500, 1'b0, 1'b1);
    send_fields(16'd150, 16'hFFFF, 16'd500, 16'd2000, 1'b1, 1'b0);
    send_fields(16'd150, 16'd1234, 16'd500, 16'd500, 1'b0, 1'b0);
    // a normal window lets the fault clear
    write_limit(REG_VOLTAGE_LOW, 16'd100);
    write_limit(REG_VOLTAGE_HIGH, 16'd60000);
    send_fields(16'd150, 16'd1234, 16'd500, 16'd500, 1'b1, 1'b1);
    // a margin wider than the window: once set, the fault stays
    write_limit(REG_VOLTAGE_HIGH, 16'd200);
    write_limit(REG_VOLTAGE_MARGIN, 16'd60000);
    send_fields(16'd150, 16'd1234, 16'd500, 16'd50, 1'b0, 1'b0);
    send_fields(16'd150, 16'd1234, 16'd500, 16'd150, 1'b0, 1'b1);
  endtask

  // every register at zero, then every register at all ones
  task automatic test_register_extremes();
    idle_pct = 20;
    for (int r = REG_OVERSPEED_SET; r <= REG_VIBRATION_LIMIT; r++)
      write_limit(3'(r), 16'h0000);
    raw_base = 0;
    raw_span = 3;
    repeat (60) send_snapshot(random_snapshot());
    for (int r = REG_OVERSPEED_SET; r <= REG_VIBRATION_LIMIT; r++)
      write_limit(3'(r), 16'hFFFF);
    raw_base = 0;
    raw_span = 65535;
    repeat (60) send_snapshot(random_snapshot());
  endtask

  // receiver holds off for a long stretch while items keep coming, so the
  // input stalls; then the sender waits for every report before going on
  task automatic test_backpressure();
    program_random_limits();
    idle_pct = 0;
    hold_request = 1'b1;
    repeat (40) send_snapshot(random_snapshot());
    drain_reports();
  endtask

  // several random settings with random traffic; half way through each phase
  // the sender pauses until all reports are back
  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      program_random_limits();
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      for (int i = 0; i < 100; i++) begin
        if (i == 50) drain_reports();
        send_snapshot(random_snapshot());
      end
    end
  endtask

  // last stretch at full rate, no idling on either side
  task automatic test_full_rate();
    program_random_limits();
    idle_pct = 0;
    repeat (150) send_snapshot(random_snapshot());
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    rst                             = 1'b1;
    psel                            = 1'b0;
    penable                         = 1'b0;
    pwrite                          = 1'b0;
    paddr                           = '0;
    pwdata                          = '0;
    snapshot_ch.valid               = 1'b0;
    snapshot_ch.speed_rpm           = 16'h0000;
    snapshot_ch.filtered_current_ma = 16'h0000;
    snapshot_ch.raw_current_ma      = 16'h0000;
    snapshot_ch.supply_mv           = 16'h0000;
    snapshot_ch.lid_is_open         = 1'b0;
    snapshot_ch.adc_fault           = 1'b0;
    reset_predictor();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_threshold_corners();
    test_register_extremes();
    test_backpressure();
    test_random_settings();
    test_full_rate();

    // all owed reports back, then a quiet stretch to catch anything extra
    drain_reports();
    repeat (DUT_LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
